// ----- rtl/e2n_pkg.sv -----
`timescale 1ns / 1ps
// Package for the edge-to-node reduce core: codes, field widths and memory entry type.
// No dependencies.
package e2n_pkg;

  localparam int unsigned NODE_W    = 10;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [MODE_W-1:0] MODE_MAX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUM = 3'd5;
  localparam logic [MODE_W-1:0] MODE_AVG = 3'd6;

  localparam logic [S_TUSER_W-1:0] KIND_EDGE  = 2'd0;
  localparam logic [S_TUSER_W-1:0] KIND_READ  = 2'd1;
  localparam logic [S_TUSER_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [COUNT_W-1:0]      cnt;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_UPD   = 6'b000100,
    S_DIV   = 6'b001000,
    S_SGN   = 6'b010000,
    S_CLEAR = 6'b100000
  } state_e;

endpackage

// ----- rtl/edge_to_node_reduce_core.sv -----
`timescale 1ns / 1ps
// Edge-to-node reduce core: node memory, shared 33-bit adder and sequencer.
// Depends on e2n_pkg.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: node_a, node_b, edge_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: node_value, contrib_count, dropped
// cfg       in   cfg_valid/cfg_ready          cfg_data: combine_mode
//
// Edge beat: accepted in idle, then a read and an update per endpoint in range, a read alone per endpoint out.
// Read beat: accepted, then read, update and output load; in average mode with a nonzero count
//   also the bit-serial divide and sign fix-up on the shared adder. A node out of range skips update.
// Clear beat and reset: sweep through the node memory, one entry a cycle.
// The output register holds a result while the next beat is accepted; a new result waits
//   for it to drain. Configuration writes are taken in every cycle.
module edge_to_node_reduce_core
  import e2n_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [9:0] node_a, [19:10] node_b, [35:20] edge_value, [39:36] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [31:0] node_value, [47:32] contrib_count, [48] dropped, [55:49] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MODE_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [16:0] NODES_W = 17'(NODES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);
  localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

  state_e state_q, state_d;

  logic [MODE_W-1:0]         mode_q;
  logic                      drop_q;
  logic [AW-1:0]             clr_q;
  logic [NODE_W-1:0]         node_a_q, node_b_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      is_read_q;
  logic                      second_q;
  logic [ACC_W-1:0]          quo_q;
  logic [COUNT_W-1:0]        rem_q;
  logic [COUNT_W-1:0]        cnt_q;
  logic                      neg_q;
  logic [4:0]                step_q;
  logic                      out_valid_q;
  logic [M_TDATA_W-1:0]      out_data_q;
  logic                      out_pend_q;

  entry_t mem [NODES];
  entry_t rd_q;
  entry_t wr_data;
  logic   wr_en;
  logic [AW-1:0] wr_addr;

  logic [NODE_W-1:0] cur_node;
  logic              cur_in_range;
  logic [AW-1:0]     cur_idx;
  logic signed [ACC_W-1:0] v32;
  logic [ACC_W:0]    add_a, add_b, add_sum;
  logic              add_sub;
  logic [COUNT_W:0]  rem_sh;
  logic [ACC_W-1:0]  comb_val;
  logic              out_free;
  logic              in_beat;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE) && !out_pend_q;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign cur_node     = second_q ? node_b_q : node_a_q;
  assign cur_in_range = {7'd0, cur_node} < NODES_W;
  assign cur_idx      = AW'(cur_node);
  assign v32          = ACC_W'(value_q);
  assign rem_sh       = {rem_q, quo_q[ACC_W-1]};

  // Shared adder: combine, magnitude, divide step and sign fix-up
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_UPD: begin
        if (is_read_q) begin
          add_b   = {rd_q.acc[ACC_W-1], rd_q.acc};
          add_sub = 1'b1;
        end else begin
          add_a   = {rd_q.acc[ACC_W-1], rd_q.acc};
          add_b   = {v32[ACC_W-1], v32};
          add_sub = (mode_q == MODE_MAX) || (mode_q == MODE_MIN);
        end
      end
      S_DIV: begin
        add_a   = (ACC_W + 1)'(rem_sh);
        add_b   = (ACC_W + 1)'(cnt_q);
        add_sub = 1'b1;
      end
      S_SGN: begin
        add_b   = {1'b0, quo_q};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + (ACC_W + 1)'(add_sub);
  end

  always_comb begin
    if (rd_q.cnt == '0) begin
      comb_val = v32;
    end else begin
      unique case (mode_q)
        MODE_MAX: comb_val = add_sum[ACC_W] ? v32 : rd_q.acc;
        MODE_MIN: comb_val = (!add_sum[ACC_W] && (|add_sum)) ? v32 : rd_q.acc;
        MODE_AND: comb_val = rd_q.acc & v32;
        MODE_OR:  comb_val = rd_q.acc | v32;
        MODE_SUM, MODE_AVG: comb_val = add_sum[ACC_W-1:0];
        default:  comb_val = rd_q.acc;
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = '0;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
    end else if ((state_q == S_UPD) && !is_read_q && (rd_q.cnt != COUNT_SAT)) begin
      wr_en       = 1'b1;
      wr_data.acc = comb_val;
      wr_data.cnt = rd_q.cnt + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[cur_idx];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          priority if (s_axis_tuser_i == KIND_CLEAR) begin
            state_d = S_CLEAR;
          end else if ((s_axis_tuser_i == KIND_EDGE) || (s_axis_tuser_i == KIND_READ)) begin
            state_d = S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RD: begin
        if (cur_in_range) begin
          state_d = S_UPD;
        end else if (!is_read_q && !second_q) begin
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_UPD: begin
        if (is_read_q) begin
          state_d = ((mode_q == MODE_AVG) && (rd_q.cnt != '0)) ? S_DIV : S_IDLE;
        end else begin
          state_d = second_q ? S_IDLE : S_RD;
        end
      end
      S_DIV:   state_d = (step_q == LAST_STEP) ? S_SGN : S_DIV;
      S_SGN:   state_d = S_IDLE;
      S_CLEAR: state_d = (clr_q == LAST_IDX) ? S_IDLE : S_CLEAR;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= MODE_MAX;
      drop_q      <= 1'b0;
      clr_q       <= '0;
      second_q    <= 1'b0;
      is_read_q   <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + AW'(1);
      end
      if (in_beat) begin
        second_q  <= 1'b0;
        is_read_q <= (s_axis_tuser_i == KIND_READ);
        if (s_axis_tuser_i == KIND_CLEAR) begin
          drop_q <= 1'b0;
        end
      end
      if ((state_q == S_RD) && !cur_in_range && !is_read_q) begin
        second_q <= 1'b1;
      end
      if ((state_q == S_UPD) && !is_read_q) begin
        second_q <= 1'b1;
        if (rd_q.cnt == COUNT_SAT) begin
          drop_q <= 1'b1;
        end
      end
      if ((state_q == S_UPD) && is_read_q) begin
        step_q <= '0;
      end else if (state_q == S_DIV) begin
        step_q <= step_q + 5'd1;
      end
      // Hold a finished result until the output register drains
      if (((state_q == S_RD) && !cur_in_range && is_read_q) ||
          ((state_q == S_UPD) && is_read_q && (state_d == S_IDLE)) ||
          (state_q == S_SGN)) begin
        out_pend_q <= 1'b1;
      end else if (out_pend_q && out_free) begin
        out_pend_q <= 1'b0;
      end
      if (out_pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      node_a_q <= s_axis_tdata_i[NODE_W-1:0];
      node_b_q <= s_axis_tdata_i[2*NODE_W-1:NODE_W];
      value_q  <= s_axis_tdata_i[2*NODE_W+VALUE_W-1:2*NODE_W];
    end
    if ((state_q == S_RD) && !cur_in_range) begin
      quo_q <= '0;
      cnt_q <= '0;
    end
    if ((state_q == S_UPD) && is_read_q) begin
      cnt_q <= rd_q.cnt;
      rem_q <= '0;
      neg_q <= rd_q.acc[ACC_W-1];
      if (rd_q.cnt == '0) begin
        quo_q <= '0;
      end else if (mode_q == MODE_AVG) begin
        quo_q <= rd_q.acc[ACC_W-1] ? add_sum[ACC_W-1:0] : rd_q.acc;
      end else begin
        quo_q <= rd_q.acc;
      end
    end
    if (state_q == S_DIV) begin
      if (!add_sum[ACC_W]) begin
        rem_q <= add_sum[COUNT_W-1:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[COUNT_W-1:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b0};
      end
    end
    if ((state_q == S_SGN) && neg_q) begin
      quo_q <= add_sum[ACC_W-1:0];
    end
    if (out_pend_q && out_free) begin
      out_data_q <= {7'd0, drop_q, cnt_q, quo_q};
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q != '0))
    else $error("divide step with zero count");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < cnt_q))
    else $error("remainder not below divisor");

  a_clear_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !drop_q)
    else $error("drop flag set during clear sweep");

  a_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pend_q && out_free) |=> (m_axis_tvalid_o && !out_pend_q))
    else $error("pending result not loaded");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for edge_to_node_reduce_core: directed and random beats, checked
// against a node memory predictor kept in step with every accepted beat. Depends on e2n_pkg.
module testbench;
  import e2n_pkg::*;

  localparam int unsigned NODE_COUNT    = 1024;
  localparam int unsigned SETTLE_CYCLES = NODE_COUNT + 64;
  localparam int unsigned FINAL_WAIT    = 20000;
  localparam int unsigned DUE_DEPTH     = 16;
  localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd0;
  localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
  localparam logic [S_TUSER_W-1:0] KIND_SPARE    = 2'd3;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [COUNT_W-1:0]      count;
    logic                    dropped;
  } node_read_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic [S_TUSER_W-1:0] s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [MODE_W-1:0]    cfg_data_i;

  logic signed [ACC_W-1:0] acc_pred [1024];
  logic [COUNT_W-1:0]      count_pred [1024];
  logic                    drop_pred;
  logic [MODE_W-1:0]       mode_pred;
  node_read_t              node_reads_due [DUE_DEPTH];
  int unsigned             due_wr;
  int unsigned             due_rd;
  node_read_t              oldest_read;
  int                      error_count;
  int                      hold_len;
  bit                      idle_on;

  edge_to_node_reduce_core #(
    .NODES(NODE_COUNT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    error_count++;
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
  endtask

  function automatic void expect_read(input node_read_t rd);
    node_reads_due[due_wr % DUE_DEPTH] = rd;
    due_wr++;
  endfunction

  function automatic node_read_t take_read();
    node_read_t rd;
    rd = node_reads_due[due_rd % DUE_DEPTH];
    due_rd++;
    return rd;
  endfunction

  function automatic void merge_contribution(input logic [NODE_W-1:0] node,
                                             input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (node >= NODE_COUNT) return;
    if (count_pred[node] == COUNT_SAT) begin
      drop_pred = 1'b1;
      return;
    end
    if (count_pred[node] == '0) begin
      acc_pred[node] = v;
    end else begin
      r = acc_pred[node];
      case (mode_pred)
        MODE_MAX: if (v > r) r = v;
        MODE_MIN: if (v < r) r = v;
        MODE_AND: r = r & v;
        MODE_OR:  r = r | v;
        MODE_SUM, MODE_AVG: r = r + v;
        default: ;
      endcase
      acc_pred[node] = r;
    end
    count_pred[node] = count_pred[node] + 1'b1;
  endfunction

  function automatic void predict_beat(input logic [S_TUSER_W-1:0] kind,
                                       input logic [NODE_W-1:0] node_a,
                                       input logic [NODE_W-1:0] node_b,
                                       input logic signed [VALUE_W-1:0] value);
    node_read_t rd;
    case (kind)
      KIND_EDGE: begin
        merge_contribution(node_a, value);
        merge_contribution(node_b, value);
      end
      KIND_CLEAR: begin
        foreach (count_pred[i]) count_pred[i] = '0;
        drop_pred = 1'b0;
      end
      KIND_READ: begin
        rd.value   = '0;
        rd.count   = '0;
        rd.dropped = drop_pred;
        if (node_a < NODE_COUNT) begin
          rd.count = count_pred[node_a];
          if (rd.count != '0) begin
            rd.value = acc_pred[node_a];
            if (mode_pred == MODE_AVG) rd.value = rd.value / $signed({16'd0, rd.count});
          end
        end
        expect_read(rd);
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [S_TUSER_W-1:0] kind, input logic [NODE_W-1:0] node_a,
                           input logic [NODE_W-1:0] node_b,
                           input logic signed [VALUE_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {4'd0, value, node_b, node_a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_beat(kind, node_a, node_b, value);
  endtask

  task automatic await_idle();
    s_axis_tvalid_i <= 1'b0;
    while (due_wr != due_rd) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_combine_mode(input logic [MODE_W-1:0] mode);
    await_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_pred = mode;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] random_node(input int unsigned hot_base);
    if ($urandom_range(0, 3) != 0) return NODE_W'(hot_base + $urandom_range(0, 15));
    return NODE_W'($urandom_range(0, 1023));
  endfunction

  task automatic test_untouched_and_ignored();
    send_beat(KIND_READ, 10'd0, 10'd0, 16'sd0);
    send_beat(KIND_EDGE, 10'd1000, 10'd1023, 16'sh7FFF);
    send_beat(KIND_READ, 10'd1023, 10'd0, 16'sd0);
    send_beat(KIND_SPARE, 10'h3FF, 10'h3FF, 16'shFFFF);
    send_beat(KIND_EDGE, 10'd0, 10'd0, -16'sd1);
    send_beat(KIND_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_beat(KIND_READ, 10'd0, 10'd0, 16'sd0);
  endtask

  task automatic test_each_mode();
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] node;
    for (int m = 0; m < 8; m++) begin
      mode = MODE_W'(m);
      node = NODE_W'(16 + 2 * m);
      set_combine_mode(mode);
      send_beat(KIND_EDGE, node, node, 16'sh8000);
      send_beat(KIND_EDGE, node, 10'd1023, 16'sh7FFF);
      send_beat(KIND_READ, node, 10'd0, 16'sd0);
    end
  endtask

  task automatic test_sum_then_average();
    logic [NODE_W-1:0] node;
    node = NODE_W'($urandom_range(0, NODE_COUNT - 1));
    set_combine_mode(MODE_SUM);
    idle_on = 1'b0;
    send_beat(KIND_CLEAR, 10'd0, 10'd0, 16'sd0);
    repeat (40) send_beat(KIND_EDGE, node, node, random_value());
    send_beat(KIND_READ, node, 10'd0, 16'sd0);
    send_beat(KIND_EDGE, node, node, random_value());
    send_beat(KIND_READ, node, 10'd0, 16'sd0);
    send_beat(KIND_READ, node ^ 10'd1, 10'd0, 16'sd0);
    set_combine_mode(MODE_AVG);
    send_beat(KIND_READ, node, 10'd0, 16'sd0);
    send_beat(KIND_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_beat(KIND_READ, node, 10'd0, 16'sd0);
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int unsigned hot_base;
    hot_base = $urandom_range(0, NODE_COUNT - 16);
    set_combine_mode(MODE_MAX);
    hold_len = 300;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        send_beat(KIND_EDGE, random_node(hot_base), random_node(hot_base), random_value());
      else
        send_beat(KIND_READ, random_node(hot_base), NODE_W'($urandom()), random_value());
    end
    await_idle();
  endtask

  task automatic test_random_traffic();
    logic [MODE_W-1:0] plan [10] = '{MODE_MAX, MODE_AVG, MODE_MIN, MODE_SUM, MODE_AND,
                                     MODE_SPARE_HI, MODE_OR, MODE_AVG, MODE_SPARE_LO,
                                     MODE_MAX};
    int unsigned hot_base;
    int unsigned pick;
    int          sent;
    for (int p = 0; p < 10; p++) begin
      set_combine_mode(plan[p]);
      if (p == 9) idle_on = 1'b0;
      hot_base = $urandom_range(0, 1007);
      sent = 0;
      while (sent < 133) begin
        pick = $urandom_range(0, 99);
        if (pick < 58 || pick == 99) begin
          send_beat(KIND_EDGE, random_node(hot_base), random_node(hot_base), random_value());
          sent++;
        end else if (pick < 96) begin
          send_beat(KIND_READ, random_node(hot_base), NODE_W'($urandom()),
                    VALUE_W'($urandom()));
          sent++;
        end else if (pick < 98) begin
          send_beat(KIND_SPARE, NODE_W'($urandom()), NODE_W'($urandom()),
                    VALUE_W'($urandom()));
        end else begin
          send_beat(KIND_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()),
                    VALUE_W'($urandom()));
          sent++;
        end
      end
    end
  endtask

  initial begin : drive_ready
    int n;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        m_axis_tready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        if (idle_on) repeat ($urandom_range(0, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_wr == due_rd) begin
        report_mismatch("unexpected result, node_value", $signed(m_axis_tdata_o[31:0]), 0);
      end else begin
        oldest_read = take_read();
        if (m_axis_tdata_o[31:0] !== oldest_read.value)
          report_mismatch("node_value", $signed(m_axis_tdata_o[31:0]), oldest_read.value);
        if (m_axis_tdata_o[47:32] !== oldest_read.count)
          report_mismatch("contrib_count", m_axis_tdata_o[47:32], oldest_read.count);
        if (m_axis_tdata_o[48] !== oldest_read.dropped)
          report_mismatch("dropped", m_axis_tdata_o[48], oldest_read.dropped);
      end
    end
  end

  initial begin
    error_count = 0;
    hold_len    = 0;
    idle_on     = 1'b1;
    due_wr      = 0;
    due_rd      = 0;
    mode_pred   = MODE_MAX;
    drop_pred   = 1'b0;
    foreach (count_pred[i]) begin
      count_pred[i] = '0;
      acc_pred[i]   = '0;
    end
    rst_ni          = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= KIND_EDGE;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= MODE_MAX;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_untouched_and_ignored();
    test_each_mode();
    test_sum_then_average();
    test_output_backpressure();
    test_random_traffic();

    idle_on = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    for (int i = 0; i < FINAL_WAIT && due_wr != due_rd; i++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (due_wr != due_rd) begin
      oldest_read = take_read();
      report_mismatch("missing result, node_value", 0, oldest_read.value);
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
